FILE: src/ial_pkg.sv
// shared types and constants of the indexed array list
package ial_pkg;

	// field widths of the request and response items
	localparam int REQ_TYPE_W = 3;
	localparam int POSITION_W = 7;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_APPEND      = 3'd0,
		REQ_INSERT      = 3'd1,
		REQ_REMOVE_AT   = 3'd2,
		REQ_READ_AT     = 3'd3,
		REQ_CLEAR       = 3'd4,
		REQ_READ_LAST   = 3'd5,
		REQ_REMOVE_LAST = 3'd6
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		SH_HOLD   = 2'd0,
		SH_INSERT = 2'd1,
		SH_REMOVE = 2'd2
	} shift_t;

endpackage

FILE: src/ial_req_if.sv
// request channel of the indexed array list
interface ial_req_if import ial_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [POSITION_W-1:0] position;
	logic [VALUE_W-1:0]    entry_value;
	logic                  value_given;

	modport source (output valid, req_type, position, entry_value, value_given, input ready);
	modport sink (input valid, req_type, position, entry_value, value_given, output ready);
endinterface

FILE: src/ial_rsp_if.sv
// response channel of the indexed array list
interface ial_rsp_if import ial_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  read_data;
	logic [COUNT_W-1:0]  count_now;

	modport source (output valid, status, read_data, count_now, input ready);
	modport sink (input valid, status, read_data, count_now, output ready);
endinterface

FILE: src/ial_cell.sv
// one entry cell: holds an entry, shifts from its neighbors, drives its entry on a hit
module ial_cell import ial_pkg::*; #(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int EW  = 32
) (
	input  logic          clk,
	input  shift_t        mode,
	input  logic [IW-1:0] pos,
	input  logic [EW-1:0] wr_value,
	input  logic [EW-1:0] left_entry,
	input  logic [EW-1:0] right_entry,
	output logic [EW-1:0] entry,
	output logic [EW-1:0] rd_part
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [EW-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (mode)
			SH_INSERT: begin
				if (MY_IDX == pos) begin
					entry_q <= wr_value;
				end else if (MY_IDX > pos) begin
					entry_q <= left_entry;
				end
			end
			SH_REMOVE: begin
				if (MY_IDX >= pos) begin
					entry_q <= right_entry;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry   = entry_q;
	assign rd_part = (MY_IDX == pos) ? entry_q : '0;

endmodule

FILE: src/indexed_array_list.sv
// top level of the indexed array list: decode, count, cell row and response register
//
// an ordered list of up to MAX_ENTRIES entries of ENTRY_WIDTH bits each
// req channel: one item is one request (append, insert, remove at, read at,
//   clear, read last, remove last); position and entry_value as the request needs
// rsp channel: exactly one item per request with status, read_data, count_now
// each entry lives in its own cell; insert shifts the cells above the index up
//   by one, remove shifts the cells from the index on down by one, all cells move together
// the response item is registered and valid in the cycle after the request is taken
// throughput: one request per cycle while rsp is not stalled; the cell row and the count
//   update in the cycle the request is accepted, so nothing waits on a previous request
// a single response register parts the channels: while rsp is stalled the
//   register holds, and req is taken again as soon as the response drains
//   or in the same cycle it is taken
// reset clears the entry count and the response valid; the cells keep
//   whatever they held, only entries below the count are ever read
// failed requests (bad index, full, empty) leave the list unchanged
module indexed_array_list import ial_pkg::*; #(
	parameter int MAX_ENTRIES = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	ial_req_if.sink   req,
	ial_rsp_if.source rsp
);

	localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

	// list state
	logic [CW-1:0] count_q;

	// response register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  data_q;
	logic [COUNT_W-1:0]  count_now_q;

	// decode results
	logic                fire;
	shift_t              mode;
	logic [IW-1:0]       cell_pos;
	logic [CW-1:0]       count_nxt;
	status_t             status_nxt;
	logic [VALUE_W-1:0]  data_nxt;
	logic [CMPW-1:0]     pos_ext;
	logic [CMPW-1:0]     cnt_ext;
	logic                full;
	logic                empty;
	logic [CW-1:0]       last_idx;
	logic [63:0]         value_wide;
	logic [ENTRY_WIDTH-1:0] wr_value;
	logic [63:0]         rd_wide;
	logic [VALUE_W-1:0]  rd_data;
	logic [VALUE_W-1:0]  wr_data;

	// cell row
	logic [ENTRY_WIDTH-1:0] entry   [MAX_ENTRIES];
	logic [ENTRY_WIDTH-1:0] rd_part [MAX_ENTRIES];
	logic [ENTRY_WIDTH-1:0] rd_entry;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	// value to store: zero when absent, cut or widened to the entry width
	assign value_wide = req.value_given ? {32'b0, req.entry_value} : 64'b0;
	assign wr_value   = value_wide[ENTRY_WIDTH-1:0];
	assign wr_data    = VALUE_W'(64'(wr_value));

	assign pos_ext  = CMPW'(req.position);
	assign cnt_ext  = CMPW'(count_q);
	assign full     = (count_q == FULL_COUNT);
	assign empty    = (count_q == '0);
	assign last_idx = count_q - CW'(1);

	// entry picked by the index, gathered from the cells
	always_comb begin
		rd_entry = '0;
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			rd_entry = rd_entry | rd_part[k];
		end
	end
	assign rd_wide = 64'(rd_entry);
	assign rd_data = rd_wide[VALUE_W-1:0];

	// request decode: append and remove last map onto insert and remove at
	always_comb begin
		mode       = SH_HOLD;
		cell_pos   = IW'(req.position);
		count_nxt  = count_q;
		status_nxt = ST_OK;
		data_nxt   = '0;
		case (req.req_type)
			REQ_APPEND: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mode      = SH_INSERT;
					cell_pos  = IW'(count_q);
					count_nxt = count_q + CW'(1);
					data_nxt  = wr_data;
				end
			end
			REQ_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_nxt = ST_RANGE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					mode      = SH_INSERT;
					count_nxt = count_q + CW'(1);
					data_nxt  = wr_data;
				end
			end
			REQ_REMOVE_AT: begin
				if (pos_ext >= cnt_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					mode      = SH_REMOVE;
					count_nxt = last_idx;
					data_nxt  = rd_data;
				end
			end
			REQ_READ_AT: begin
				if (pos_ext >= cnt_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					data_nxt = rd_data;
				end
			end
			REQ_CLEAR: begin
				count_nxt = '0;
			end
			REQ_READ_LAST: begin
				cell_pos = IW'(last_idx);
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					data_nxt = rd_data;
				end
			end
			REQ_REMOVE_LAST: begin
				cell_pos = IW'(last_idx);
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					mode      = SH_REMOVE;
					count_nxt = last_idx;
					data_nxt  = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	// row of entry cells, each shifting from its neighbors
	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left_entry;
		logic [ENTRY_WIDTH-1:0] right_entry;

		if (k == 0) begin : g_first
			assign left_entry = '0;
		end else begin : g_left
			assign left_entry = entry[k-1];
		end

		if (k == MAX_ENTRIES - 1) begin : g_last
			assign right_entry = entry[k];
		end else begin : g_right
			assign right_entry = entry[k+1];
		end

		ial_cell #(
			.IDX (k),
			.IW  (IW),
			.EW  (ENTRY_WIDTH)
		) u_cell (
			.clk         (clk),
			.mode        (fire ? mode : SH_HOLD),
			.pos         (cell_pos),
			.wr_value    (wr_value),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entry[k]),
			.rd_part     (rd_part[k])
		);
	end

	// entry count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_nxt;
			data_q      <= data_nxt;
			count_now_q <= COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.read_data = data_q;
	assign rsp.count_now = count_now_q;

endmodule
